/* rtl/core/cglm_pkg.sv */
// Shared constants and types for the conflict-graph lock manager.
// Holds sizes, operation and status codes, and the memory request structs.
// No dependencies.
package cglm_pkg;

	localparam int BLOCKS      = 16;
	localparam int COUNT_WIDTH = 8;
	localparam int IDX_W       = $clog2(BLOCKS);
	localparam int WALK_W      = IDX_W + 1;
	localparam int CFG_W       = 5;
	localparam int OP_W        = 3;
	localparam int BLK_W       = 4;
	localparam int STATUS_W    = 3;
	localparam int MASK_W      = 16;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 24;

	localparam logic [CFG_W-1:0]       CFG_RESET = CFG_W'(16);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_MUTUAL = 3'd1;
	localparam logic [OP_W-1:0] OP_COMMIT = 3'd2;
	localparam logic [OP_W-1:0] OP_LOCK   = 3'd3;
	localparam logic [OP_W-1:0] OP_UNLOCK = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PHASE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DUP   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVER  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_UNDER = 3'd6;

	// dependency row memory access: one write and one read per cycle
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [BLOCKS-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} dep_req_t;

	// hold counter memory access: one write and one read per cycle
	typedef struct packed {
		logic                   we;
		logic [IDX_W-1:0]       waddr;
		logic [COUNT_WIDTH-1:0] wdata;
		logic [IDX_W-1:0]       raddr;
	} cnt_req_t;

endpackage

/* rtl/core/cglm_store.sv */
// Dependency row and hold counter memories of the lock manager.
// Synchronous (registered) read; per-entry valid bits make reset clear both.
// Depends on cglm_pkg.
module cglm_store
	import cglm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  dep_req_t               dep_req,
	output logic [BLOCKS-1:0]      dep_rdata,
	input  cnt_req_t               cnt_req,
	output logic [COUNT_WIDTH-1:0] cnt_rdata
);

	logic [BLOCKS-1:0]      dep_mem [BLOCKS];
	logic [COUNT_WIDTH-1:0] cnt_mem [BLOCKS];
	logic [BLOCKS-1:0]      dep_vld_q;
	logic [BLOCKS-1:0]      cnt_vld_q;
	logic [BLOCKS-1:0]      dep_rd_q;
	logic [COUNT_WIDTH-1:0] cnt_rd_q;
	logic                   dep_rd_vld_q;
	logic                   cnt_rd_vld_q;

	// memory arrays: write port and registered read port
	always_ff @(posedge clk) begin
		if (dep_req.we) begin
			dep_mem[dep_req.waddr] <= dep_req.wdata;
		end
		if (cnt_req.we) begin
			cnt_mem[cnt_req.waddr] <= cnt_req.wdata;
		end
		dep_rd_q <= dep_mem[dep_req.raddr];
		cnt_rd_q <= cnt_mem[cnt_req.raddr];
	end

	// valid bits: an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_vld_q    <= '0;
			cnt_vld_q    <= '0;
			dep_rd_vld_q <= 1'b0;
			cnt_rd_vld_q <= 1'b0;
		end else begin
			dep_rd_vld_q <= dep_vld_q[dep_req.raddr];
			cnt_rd_vld_q <= cnt_vld_q[cnt_req.raddr];
			if (dep_req.we) begin
				dep_vld_q[dep_req.waddr] <= 1'b1;
			end
			if (cnt_req.we) begin
				cnt_vld_q[cnt_req.waddr] <= 1'b1;
			end
		end
	end

	assign dep_rdata = dep_rd_vld_q ? dep_rd_q : '0;
	assign cnt_rdata = cnt_rd_vld_q ? cnt_rd_q : '0;

endmodule

/* rtl/core/conflict_graph_lock_manager_unit.sv */
// Conflict-graph lock manager: request sequencer, config register, result register.
// Instantiates cglm_store; depends on cglm_pkg.
//
// Usage:
//   s_* channel takes one request beat (operation, first block, second block).
//   m_* channel returns exactly one result beat (status, released mask) per request.
//   cfg_wr_en/cfg_wr_data write blocks_in_use; write only while no request is open.
// Sequencing (one request at a time, s_tready is low while one is open):
//   range/phase errors and commit: from accept straight to S_DONE and the result register.
//   busy lock: S_ROW_A, then S_DONE.
//   add dependency: S_ROW_A, S_ROW_B; mutual add also S_WR_B (row reads and write-backs).
//   lock/unlock: S_ROW_A, S_CHECK, S_UPDATE, then S_DONE. The hold counter
//   memory is walked one entry per cycle, once to check for overflow or
//   underflow and, if that passes, once more to read-modify-write the counters.
//   The next beat is taken once the result register has been loaded.
// Reset: dependency rows and counters read as zero (per-entry valid bits), the
//   graph is uncommitted, blocks_in_use is 16; no clearing pass is needed.
// Stall: a finished result waits in the result register until m_tready; the
//   next request is taken once the result has been loaded there.
module conflict_graph_lock_manager_unit
	import cglm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] operation, [6:3] first_block, [10:7] second_block
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] status, [18:3] released_mask
	input  logic                 cfg_wr_en,
	input  logic [CFG_W-1:0]     cfg_wr_data
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_ROW_A  = 7'b0000010,
		S_ROW_B  = 7'b0000100,
		S_WR_B   = 7'b0001000,
		S_CHECK  = 7'b0010000,
		S_UPDATE = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       blocks_q;
	logic                   frozen_q;
	logic [OP_W-1:0]        op_q;
	logic [IDX_W-1:0]       a_q;
	logic [IDX_W-1:0]       b_q;
	logic [BLOCKS-1:0]      row_q;
	logic [BLOCKS-1:0]      rowb_q;
	logic [STATUS_W-1:0]    status_q;
	logic [MASK_W-1:0]      released_q;
	logic                   fail_q;
	logic [WALK_W-1:0]      idx_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic                   rd_live_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	logic [OP_W-1:0]        in_op;
	logic [IDX_W-1:0]       in_a;
	logic [IDX_W-1:0]       in_b;
	logic                   in_add;
	logic                   a_ok;
	logic                   b_ok;
	logic                   op_add;
	logic                   op_lock;
	logic                   dup_b;
	logic                   walk_end;
	logic                   walk_hit;
	logic                   chk_bad;
	dep_req_t               dep_req;
	cnt_req_t               cnt_req;
	logic [BLOCKS-1:0]      dep_rdata;
	logic [COUNT_WIDTH-1:0] cnt_rdata;

	cglm_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.dep_req   (dep_req),
		.dep_rdata (dep_rdata),
		.cnt_req   (cnt_req),
		.cnt_rdata (cnt_rdata)
	);

	// request field decode and range check against blocks_in_use
	assign in_op    = s_tdata[OP_W-1:0];
	assign in_a     = s_tdata[OP_W +: BLK_W];
	assign in_b     = s_tdata[OP_W+BLK_W +: BLK_W];
	assign in_add   = (in_op == OP_ADD) || (in_op == OP_MUTUAL);
	assign a_ok     = CFG_W'(in_a) < blocks_q;
	assign b_ok     = CFG_W'(in_b) < blocks_q;
	assign op_add   = (op_q == OP_ADD) || (op_q == OP_MUTUAL);
	assign op_lock  = (op_q == OP_LOCK);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// duplicate check once both rows are in hand (second row arrives now)
	assign dup_b = row_q[b_q] || ((op_q == OP_MUTUAL) && (a_q != b_q) && dep_rdata[a_q]);

	// counter walk: data for rd_idx_q arrives in the cycle after its read
	assign walk_end = (idx_q == WALK_W'(BLOCKS));
	assign walk_hit = rd_live_q && row_q[rd_idx_q];
	assign chk_bad  = walk_hit && (op_lock ? (cnt_rdata == CNT_MAX) : (cnt_rdata == '0));

	// memory port control
	always_comb begin
		dep_req = '0;
		cnt_req = '0;
		unique case (state_q)
			S_IDLE: begin
				dep_req.raddr = in_a;
				cnt_req.raddr = in_a;
			end
			S_ROW_A: begin
				dep_req.raddr = b_q;
			end
			S_ROW_B: begin
				dep_req.we    = !dup_b;
				dep_req.waddr = a_q;
				dep_req.wdata = row_q | (BLOCKS'(1) << b_q);
			end
			S_WR_B: begin
				dep_req.we    = 1'b1;
				dep_req.waddr = b_q;
				dep_req.wdata = rowb_q | (BLOCKS'(1) << a_q);
			end
			S_CHECK: begin
				cnt_req.raddr = idx_q[IDX_W-1:0];
			end
			S_UPDATE: begin
				cnt_req.raddr = idx_q[IDX_W-1:0];
				cnt_req.we    = walk_hit;
				cnt_req.waddr = rd_idx_q;
				cnt_req.wdata = op_lock ? (cnt_rdata + COUNT_WIDTH'(1))
				                        : (cnt_rdata - COUNT_WIDTH'(1));
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			blocks_q   <= CFG_RESET;
			frozen_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			idx_q      <= '0;
			rd_live_q  <= 1'b0;
			fail_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				blocks_q <= cfg_wr_data;
			end
			// result beat leaves; a reload in S_DONE sets valid again
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q       <= in_op;
						a_q        <= in_a;
						b_q        <= in_b;
						released_q <= '0;
						fail_q     <= 1'b0;
						idx_q      <= '0;
						rd_live_q  <= 1'b0;
						priority if (in_op > OP_UNLOCK) begin
							status_q <= ST_RANGE;
							state_q  <= S_DONE;
						end else if (in_op == OP_COMMIT) begin
							status_q <= frozen_q ? ST_PHASE : ST_OK;
							frozen_q <= 1'b1;
							state_q  <= S_DONE;
						end else if (!a_ok || (in_add && !b_ok)) begin
							status_q <= ST_RANGE;
							state_q  <= S_DONE;
						end else if (frozen_q == in_add) begin
							status_q <= ST_PHASE;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_OK;
							state_q  <= S_ROW_A;
						end
					end
				end
				S_ROW_A: begin
					row_q <= dep_rdata;
					priority if (op_add) begin
						state_q <= S_ROW_B;
					end else if (op_lock && (cnt_rdata != '0)) begin
						status_q <= ST_BUSY;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_ROW_B: begin
					rowb_q <= dep_rdata;
					priority if (dup_b) begin
						status_q <= ST_DUP;
						state_q  <= S_DONE;
					end else if (op_q == OP_MUTUAL) begin
						state_q <= S_WR_B;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WR_B: begin
					state_q <= S_DONE;
				end
				S_CHECK: begin
					if (chk_bad) begin
						fail_q <= 1'b1;
					end
					if (walk_end) begin
						idx_q     <= '0;
						rd_live_q <= 1'b0;
						if (fail_q || chk_bad) begin
							status_q <= op_lock ? ST_OVER : ST_UNDER;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_UPDATE;
						end
					end else begin
						idx_q     <= idx_q + WALK_W'(1);
						rd_live_q <= 1'b1;
						rd_idx_q  <= idx_q[IDX_W-1:0];
					end
				end
				S_UPDATE: begin
					// a counter that drops from one to zero is released
					if (!op_lock && walk_hit && (cnt_rdata == COUNT_WIDTH'(1))) begin
						released_q[rd_idx_q] <= 1'b1;
					end
					if (walk_end) begin
						idx_q     <= '0;
						rd_live_q <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						idx_q     <= idx_q + WALK_W'(1);
						rd_live_q <= 1'b1;
						rd_idx_q  <= idx_q[IDX_W-1:0];
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {(M_TDATA_W-MASK_W-STATUS_W)'(0), released_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/cglm_checker.sv */
// Port-level checker for the lock manager, bound to conflict_graph_lock_manager_unit.
// Depends on cglm_pkg and conflict_graph_lock_manager_unit.
module cglm_checker
	import cglm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 cfg_wr_en
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// status is always a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[STATUS_W-1:0] <= ST_UNDER)
		else $error("undefined status code");

	// released mask only comes with an ok status
	a_mask_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK) |-> m_tdata[STATUS_W +: MASK_W] == '0)
		else $error("released mask set on a rejected request");

	// one request at a time: no beat is taken right after an accept
	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is open");

	// config writes land only with no request open and no result waiting
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> s_tready && !m_tvalid)
		else $error("config written while a request is in flight");

endmodule

bind conflict_graph_lock_manager_unit cglm_checker u_cglm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.s_tvalid    (s_tvalid),
	.s_tready    (s_tready),
	.m_tvalid    (m_tvalid),
	.m_tready    (m_tready),
	.m_tdata     (m_tdata),
	.cfg_wr_en   (cfg_wr_en)
);
